@@ rtl/core/triangle_tangent_basis_defines.svh @@
// Assertion macros used by the checker file of the tangent basis block.
`ifndef TRIANGLE_TANGENT_BASIS_DEFINES_SVH
`define TRIANGLE_TANGENT_BASIS_DEFINES_SVH

// same-cycle implication
`define TGB_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tangent basis check failed");

// next-cycle implication
`define TGB_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tangent basis check failed");

`endif

@@ rtl/core/tgb_pkg.sv @@
// Types and constants of the tangent basis block.
package tgb_pkg;
    localparam int unsigned IN_W   = 32;
    localparam int unsigned OUT_W  = 16;
    localparam int unsigned DLT_W  = 33;
    localparam int unsigned PRD_W  = 66;
    localparam int unsigned ACC_W  = 68;
    localparam int unsigned C_W    = 21;
    localparam int unsigned SUM_W  = 44;
    localparam int unsigned ROOT_W = 22;
    localparam int unsigned NUM_W  = 40;
    localparam int unsigned NUM_OPS = 14;
    localparam logic [OUT_W-1:0] ONE_Q14 = 16'd16384;

    typedef enum logic [3:0] {
        S_IDLE,
        S_MUL,
        S_ACC,
        S_LOAD,
        S_SHIFT,
        S_SQ,
        S_SQACC,
        S_SQRT,
        S_DIVINIT,
        S_DIV,
        S_DONE
    } t_state;
endpackage

@@ rtl/core/tgb_if.sv @@
// Vertex and result channel interfaces of the tangent basis block.
interface tgb_vtx_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [31:0] tex_u;
    logic signed [31:0] tex_v;
    modport source (output valid, pos_x, pos_y, pos_z, tex_u, tex_v, input ready);
    modport sink (input valid, pos_x, pos_y, pos_z, tex_u, tex_v, output ready);
endinterface

interface tgb_res_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] tan_x;
    logic signed [15:0] tan_y;
    logic signed [15:0] tan_z;
    logic signed [15:0] bitan_x;
    logic signed [15:0] bitan_y;
    logic signed [15:0] bitan_z;
    logic               degenerate;
    modport source (output valid, tan_x, tan_y, tan_z, bitan_x, bitan_y, bitan_z, degenerate,
                    input ready);
    modport sink (input valid, tan_x, tan_y, tan_z, bitan_x, bitan_y, bitan_z, degenerate,
                  output ready);
endinterface

@@ rtl/core/tgb_mul.sv @@
// Shared signed multiplier with registered product.
module tgb_mul
    import tgb_pkg::*;
(
    input  logic                    i_clk,
    input  logic signed [DLT_W-1:0] i_a,
    input  logic signed [DLT_W-1:0] i_b,
    output logic signed [PRD_W-1:0] o_p
);
    logic signed [PRD_W-1:0] r_p;

    always_ff @(posedge i_clk) begin
        r_p <= i_a * i_b;
    end

    assign o_p = r_p;
endmodule

@@ rtl/core/triangle_tangent_basis.sv @@
// Tangent basis top level: vertices arrive one per beat and every third vertex
// gives one beat of unit tangent and bitangent in Q1.14. The first two vertices
// of a triangle are only stored. The third keeps the vertex channel not ready
// until the result register is loaded, which waits for any previous result beat
// to be taken: the shared 33x33 multiplier forms the determinant and the two
// vectors, then each vector gets a load, one-bit normalizing shifts, squares on
// the same multiplier, a bit-serial square root and three restoring divisions,
// and last the result register is loaded; the vector steps are skipped when the
// determinant is zero.
module triangle_tangent_basis
    import tgb_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    tgb_vtx_if.sink    i_vtx,
    tgb_res_if.source  o_res
);
    t_state r_state, n_state;
    logic [1:0] r_cnt, n_cnt;
    logic r_ovalid, n_ovalid;

    logic signed [IN_W-1:0] r_p0 [3];
    logic signed [IN_W-1:0] r_p1 [3];
    logic signed [IN_W-1:0] r_uv0 [2];
    logic signed [IN_W-1:0] r_uv1 [2];
    logic signed [DLT_W-1:0] r_e1 [3];
    logic signed [DLT_W-1:0] r_e2 [3];
    logic signed [DLT_W-1:0] r_du1, r_dv1, r_du2, r_dv2;
    logic [3:0] r_k, n_k;
    logic signed [ACC_W-1:0] r_acc, n_acc;
    logic signed [ACC_W-1:0] r_vec [7];
    logic signed [ACC_W-1:0] n_vec [7];
    logic r_vsel, n_vsel;
    logic [ACC_W-1:0] r_mag [3];
    logic [ACC_W-1:0] n_mag [3];
    logic [2:0] r_neg, n_neg;
    logic [SUM_W-1:0] r_sum, n_sum, r_x, n_x, r_root, n_root, r_bit, n_bit;
    logic [1:0] r_ci, n_ci;
    logic [3:0] r_j, n_j;
    logic [NUM_W-1:0] r_num, n_num;
    logic [OUT_W-1:0] r_q, n_q;
    logic signed [OUT_W-1:0] r_tu [3];
    logic signed [OUT_W-1:0] r_bu [3];
    logic signed [OUT_W-1:0] n_tu [3];
    logic signed [OUT_W-1:0] n_bu [3];
    logic r_degen, n_degen;
    logic signed [OUT_W-1:0] r_ot [3];
    logic signed [OUT_W-1:0] r_ob [3];
    logic r_odeg;
    logic load_out;

    logic signed [DLT_W-1:0] mul_a, mul_b;
    logic signed [PRD_W-1:0] mul_p;
    logic signed [ACC_W-1:0] prod_x;
    logic [ACC_W-1:0] mag_or;
    logic signed [ACC_W-1:0] sv;
    logic [NUM_W-1:0] trial_d;
    logic [NUM_W:0] trial;
    logic [SUM_W-1:0] rb;
    logic [OUT_W-1:0] qc;
    logic [ROOT_W:0] dv;

    tgb_mul u_mul (
        .i_clk (i_clk),
        .i_a   (mul_a),
        .i_b   (mul_b),
        .o_p   (mul_p)
    );

    assign prod_x = {{(ACC_W-PRD_W){mul_p[PRD_W-1]}}, mul_p};
    assign i_vtx.ready = (r_state == S_IDLE);

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        if (r_state == S_SQ) begin
            mul_a = $signed({{(DLT_W-C_W){1'b0}}, r_mag[r_k[1:0]][C_W-1:0]});
            mul_b = mul_a;
        end else begin
            case (r_k)
                4'd0:  begin mul_a = r_du1; mul_b = r_dv2;   end
                4'd1:  begin mul_a = r_du2; mul_b = r_dv1;   end
                4'd2:  begin mul_a = r_dv2; mul_b = r_e1[0]; end
                4'd3:  begin mul_a = r_dv1; mul_b = r_e2[0]; end
                4'd4:  begin mul_a = r_dv2; mul_b = r_e1[1]; end
                4'd5:  begin mul_a = r_dv1; mul_b = r_e2[1]; end
                4'd6:  begin mul_a = r_dv2; mul_b = r_e1[2]; end
                4'd7:  begin mul_a = r_dv1; mul_b = r_e2[2]; end
                4'd8:  begin mul_a = r_du1; mul_b = r_e2[0]; end
                4'd9:  begin mul_a = r_du2; mul_b = r_e1[0]; end
                4'd10: begin mul_a = r_du1; mul_b = r_e2[1]; end
                4'd11: begin mul_a = r_du2; mul_b = r_e1[1]; end
                4'd12: begin mul_a = r_du1; mul_b = r_e2[2]; end
                4'd13: begin mul_a = r_du2; mul_b = r_e1[2]; end
                default: begin mul_a = '0; mul_b = '0; end
            endcase
        end
    end

    always_comb begin
        n_state = r_state;
        n_cnt = r_cnt;
        n_ovalid = r_ovalid & ~o_res.ready;
        n_k = r_k;
        n_acc = r_acc;
        n_vec = r_vec;
        n_vsel = r_vsel;
        n_mag = r_mag;
        n_neg = r_neg;
        n_sum = r_sum;
        n_x = r_x;
        n_root = r_root;
        n_bit = r_bit;
        n_ci = r_ci;
        n_j = r_j;
        n_num = r_num;
        n_q = r_q;
        n_tu = r_tu;
        n_bu = r_bu;
        n_degen = r_degen;
        load_out = 1'b0;
        mag_or = r_mag[0] | r_mag[1] | r_mag[2];
        sv = '0;
        dv = {r_root[ROOT_W-1:0], 1'b0};
        trial_d = NUM_W'({{(NUM_W-ROOT_W-1){1'b0}}, dv} << r_j);
        trial = {1'b0, r_num} - {1'b0, trial_d};
        rb = r_root + r_bit;
        qc = '0;
        case (r_state)
            S_IDLE: begin
                if (i_vtx.valid) begin
                    if (r_cnt == 2'd2) begin
                        n_cnt = 2'd0;
                        n_k = '0;
                        n_degen = 1'b0;
                        n_vsel = 1'b0;
                        n_state = S_MUL;
                    end else begin
                        n_cnt = r_cnt + 2'd1;
                    end
                end
            end
            S_MUL: n_state = S_ACC;
            S_ACC: begin
                if (!r_k[0]) begin
                    n_acc = prod_x;
                end else begin
                    n_vec[r_k[3:1]] = r_acc - prod_x;
                end
                if (r_k == 4'(NUM_OPS - 1)) begin
                    n_state = S_LOAD;
                end else begin
                    n_k = r_k + 4'd1;
                    n_state = S_MUL;
                end
            end
            S_LOAD: begin
                if (r_vec[0] == '0) begin
                    n_degen = 1'b1;
                    n_state = S_DONE;
                end else begin
                    for (int i = 0; i < 3; i++) begin
                        sv = r_vsel ? r_vec[4+i] : r_vec[1+i];
                        if (r_vec[0][ACC_W-1]) begin
                            sv = -sv;
                        end
                        n_neg[i] = sv[ACC_W-1];
                        n_mag[i] = sv[ACC_W-1] ? ACC_W'(-sv) : ACC_W'(sv);
                    end
                    n_state = S_SHIFT;
                end
            end
            S_SHIFT: begin
                if (mag_or == '0) begin
                    n_degen = 1'b1;
                    n_state = S_DONE;
                end else if (|mag_or[ACC_W-1:C_W]) begin
                    for (int i = 0; i < 3; i++) n_mag[i] = r_mag[i] >> 1;
                end else if (!mag_or[C_W-1]) begin
                    for (int i = 0; i < 3; i++) n_mag[i] = r_mag[i] << 1;
                end else begin
                    n_k = '0;
                    n_sum = '0;
                    n_state = S_SQ;
                end
            end
            S_SQ: n_state = S_SQACC;
            S_SQACC: begin
                n_sum = r_sum + mul_p[SUM_W-1:0];
                if (r_k == 4'd2) begin
                    n_x = n_sum;
                    n_root = '0;
                    n_bit = SUM_W'(1) << (SUM_W - 2);
                    n_state = S_SQRT;
                end else begin
                    n_k = r_k + 4'd1;
                    n_state = S_SQ;
                end
            end
            S_SQRT: begin
                if (r_bit == '0) begin
                    n_ci = '0;
                    n_state = S_DIVINIT;
                end else begin
                    if (r_x >= rb) begin
                        n_x = r_x - rb;
                        n_root = (r_root >> 1) + r_bit;
                    end else begin
                        n_root = r_root >> 1;
                    end
                    n_bit = r_bit >> 2;
                end
            end
            S_DIVINIT: begin
                n_num = NUM_W'({r_mag[r_ci][C_W-1:0], 15'b0})
                      + NUM_W'(r_root[ROOT_W-1:0]);
                n_j = 4'd15;
                n_q = '0;
                n_state = S_DIV;
            end
            S_DIV: begin
                if (!trial[NUM_W]) begin
                    n_num = trial[NUM_W-1:0];
                    n_q[r_j] = 1'b1;
                end
                if (r_j == 4'd0) begin
                    qc = (n_q > ONE_Q14) ? ONE_Q14 : n_q;
                    if (r_neg[r_ci]) begin
                        qc = -qc;
                    end
                    if (r_vsel) begin
                        n_bu[r_ci] = $signed(qc);
                    end else begin
                        n_tu[r_ci] = $signed(qc);
                    end
                    if (r_ci == 2'd2) begin
                        if (r_vsel) begin
                            n_state = S_DONE;
                        end else begin
                            n_vsel = 1'b1;
                            n_state = S_LOAD;
                        end
                    end else begin
                        n_ci = r_ci + 2'd1;
                        n_state = S_DIVINIT;
                    end
                end else begin
                    n_j = r_j - 4'd1;
                end
            end
            S_DONE: begin
                if (!r_ovalid || o_res.ready) begin
                    load_out = 1'b1;
                    n_ovalid = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_cnt    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_cnt    <= n_cnt;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_vtx.valid) begin
            case (r_cnt)
                2'd0: begin
                    r_p0[0] <= i_vtx.pos_x; r_p0[1] <= i_vtx.pos_y; r_p0[2] <= i_vtx.pos_z;
                    r_uv0[0] <= i_vtx.tex_u; r_uv0[1] <= i_vtx.tex_v;
                end
                2'd1: begin
                    r_p1[0] <= i_vtx.pos_x; r_p1[1] <= i_vtx.pos_y; r_p1[2] <= i_vtx.pos_z;
                    r_uv1[0] <= i_vtx.tex_u; r_uv1[1] <= i_vtx.tex_v;
                end
                default: begin
                    r_e1[0] <= {r_p1[0][31], r_p1[0]} - {r_p0[0][31], r_p0[0]};
                    r_e1[1] <= {r_p1[1][31], r_p1[1]} - {r_p0[1][31], r_p0[1]};
                    r_e1[2] <= {r_p1[2][31], r_p1[2]} - {r_p0[2][31], r_p0[2]};
                    r_e2[0] <= {i_vtx.pos_x[31], i_vtx.pos_x} - {r_p0[0][31], r_p0[0]};
                    r_e2[1] <= {i_vtx.pos_y[31], i_vtx.pos_y} - {r_p0[1][31], r_p0[1]};
                    r_e2[2] <= {i_vtx.pos_z[31], i_vtx.pos_z} - {r_p0[2][31], r_p0[2]};
                    r_du1 <= {r_uv1[0][31], r_uv1[0]} - {r_uv0[0][31], r_uv0[0]};
                    r_dv1 <= {r_uv1[1][31], r_uv1[1]} - {r_uv0[1][31], r_uv0[1]};
                    r_du2 <= {i_vtx.tex_u[31], i_vtx.tex_u} - {r_uv0[0][31], r_uv0[0]};
                    r_dv2 <= {i_vtx.tex_v[31], i_vtx.tex_v} - {r_uv0[1][31], r_uv0[1]};
                end
            endcase
        end
        r_k     <= n_k;
        r_acc   <= n_acc;
        r_vec   <= n_vec;
        r_vsel  <= n_vsel;
        r_mag   <= n_mag;
        r_neg   <= n_neg;
        r_sum   <= n_sum;
        r_x     <= n_x;
        r_root  <= n_root;
        r_bit   <= n_bit;
        r_ci    <= n_ci;
        r_j     <= n_j;
        r_num   <= n_num;
        r_q     <= n_q;
        r_tu    <= n_tu;
        r_bu    <= n_bu;
        r_degen <= n_degen;
        if (load_out) begin
            for (int i = 0; i < 3; i++) begin
                r_ot[i] <= r_degen ? '0 : r_tu[i];
                r_ob[i] <= r_degen ? '0 : r_bu[i];
            end
            r_odeg <= r_degen;
        end
    end

    assign o_res.valid      = r_ovalid;
    assign o_res.tan_x      = r_ot[0];
    assign o_res.tan_y      = r_ot[1];
    assign o_res.tan_z      = r_ot[2];
    assign o_res.bitan_x    = r_ob[0];
    assign o_res.bitan_y    = r_ob[1];
    assign o_res.bitan_z    = r_ob[2];
    assign o_res.degenerate = r_odeg;
endmodule

@@ rtl/core/tgb_checker.sv @@
// Port-level checks of the tangent basis block and their bind.
`include "triangle_tangent_basis_defines.svh"

module tgb_checker (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_valid,
    input logic              i_ready,
    input logic signed [15:0] i_tx,
    input logic signed [15:0] i_ty,
    input logic signed [15:0] i_tz,
    input logic signed [15:0] i_bx,
    input logic signed [15:0] i_by,
    input logic signed [15:0] i_bz,
    input logic              i_deg
);
    logic        tan_zero;
    logic        bitan_zero;
    logic        in_range;
    logic [96:0] beat;

    assign tan_zero   = (i_tx == 16'sd0) && (i_ty == 16'sd0) && (i_tz == 16'sd0);
    assign bitan_zero = (i_bx == 16'sd0) && (i_by == 16'sd0) && (i_bz == 16'sd0);
    assign in_range   = (i_tx <= 16'sd16384) && (i_tx >= -16'sd16384)
                     && (i_ty <= 16'sd16384) && (i_ty >= -16'sd16384)
                     && (i_tz <= 16'sd16384) && (i_tz >= -16'sd16384)
                     && (i_bx <= 16'sd16384) && (i_bx >= -16'sd16384)
                     && (i_by <= 16'sd16384) && (i_by >= -16'sd16384)
                     && (i_bz <= 16'sd16384) && (i_bz >= -16'sd16384);
    assign beat       = {i_tx, i_ty, i_tz, i_bx, i_by, i_bz, i_deg};

    `TGB_ASSERT_NOW(a_deg_zero, i_clk, i_rst_n, i_valid && i_deg, tan_zero && bitan_zero)
    `TGB_ASSERT_NOW(a_unit_nonzero, i_clk, i_rst_n, i_valid && !i_deg, !tan_zero && !bitan_zero)
    `TGB_ASSERT_NOW(a_range, i_clk, i_rst_n, i_valid, in_range)
    `TGB_ASSERT_NEXT(a_hold, i_clk, i_rst_n, i_valid && !i_ready, i_valid && $stable(beat))
endmodule

bind triangle_tangent_basis tgb_checker u_tgb_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .i_valid (o_res.valid),
    .i_ready (o_res.ready),
    .i_tx    (o_res.tan_x),
    .i_ty    (o_res.tan_y),
    .i_tz    (o_res.tan_z),
    .i_bx    (o_res.bitan_x),
    .i_by    (o_res.bitan_y),
    .i_bz    (o_res.bitan_z),
    .i_deg   (o_res.degenerate)
);
